>>> src/servo_packet_master_macros.svh
// Assertion helpers for the servo packet master.
`ifndef SERVO_PACKET_MASTER_MACROS_SVH
`define SERVO_PACKET_MASTER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SPM_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("servo_packet_master: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SPM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("servo_packet_master: assertion failed");

`endif

>>> src/spm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package spm_pkg;

  typedef enum logic [2:0] {
    REQ_PING  = 3'd0,
    REQ_READ  = 3'd1,
    REQ_WRITE = 3'd2,
    REQ_RX    = 3'd3,
    REQ_TICK  = 3'd4
  } req_type_t;

  localparam logic       CFG_SERVO_ID = 1'b0;
  localparam logic       CFG_TIMEOUT  = 1'b1;

  localparam logic       KIND_TX      = 1'b0;
  localparam logic       KIND_STATUS  = 1'b1;

  localparam logic [7:0]  HDR_BYTE      = 8'hFF;
  localparam logic [7:0]  INSTR_PING    = 8'h01;
  localparam logic [7:0]  INSTR_READ    = 8'h02;
  localparam logic [7:0]  INSTR_WRITE   = 8'h03;
  localparam logic [7:0]  ID_RESET      = 8'd1;
  localparam logic [15:0] TIMEOUT_RESET = 16'd3000;
  localparam logic [2:0]  MAX_BYTES     = 3'd4;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // One unit of work for the transmit side: a frame to send or a status.
  typedef struct packed {
    logic        is_status;
    req_type_t   cmd;
    logic [7:0]  addr;
    logic [2:0]  cnt;
    logic [7:0]  id;
    logic        ok;
    logic [7:0]  err;
    logic [31:0] data;
  } job_t;

endpackage
`default_nettype wire

>>> src/spm_front.sv
`timescale 1ns / 1ps
`default_nettype none
module spm_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                accept,
  input  wire logic [2:0]          req_type,
  input  wire logic [7:0]          reg_addr,
  input  wire logic [2:0]          byte_count,
  input  wire logic [31:0]         write_word,
  input  wire logic [7:0]          rx_byte,
  input  wire logic [7:0]          servo_id,
  input  wire logic [15:0]         timeout_us,
  output logic                     push,
  output spm_pkg::job_t            job,
  output logic                     awaiting
);

  logic        awaiting_r, awaiting_nxt;
  logic        failed_r, failed_nxt;
  logic [2:0]  expect_len_r, expect_len_nxt;
  logic [3:0]  byte_pos_r, byte_pos_nxt;
  logic [7:0]  run_sum_r, run_sum_nxt;
  logic [7:0]  last_error_r, last_error_nxt;
  logic [31:0] data_shift_r, data_shift_nxt;
  logic [15:0] elapsed_r, elapsed_nxt;

  logic [2:0]  cnt_clamped;
  logic [7:0]  sum_add;
  logic [3:0]  di;
  spm_pkg::req_type_t rt;

  assign rt          = spm_pkg::req_type_t'(req_type);
  assign cnt_clamped = (byte_count > spm_pkg::MAX_BYTES) ? spm_pkg::MAX_BYTES : byte_count;
  assign sum_add     = run_sum_r + rx_byte;
  assign di          = byte_pos_r - 4'd5;
  assign awaiting    = awaiting_r;

  always_comb begin
    awaiting_nxt   = awaiting_r;
    failed_nxt     = failed_r;
    expect_len_nxt = expect_len_r;
    byte_pos_nxt   = byte_pos_r;
    run_sum_nxt    = run_sum_r;
    last_error_nxt = last_error_r;
    data_shift_nxt = data_shift_r;
    elapsed_nxt    = elapsed_r;
    push           = 1'b0;
    job            = '0;
    if (accept) begin
      case (rt)
        spm_pkg::REQ_PING, spm_pkg::REQ_READ, spm_pkg::REQ_WRITE: begin
          awaiting_nxt   = 1'b1;
          failed_nxt     = 1'b0;
          expect_len_nxt = (rt == spm_pkg::REQ_READ) ? cnt_clamped : 3'd0;
          byte_pos_nxt   = 4'd0;
          run_sum_nxt    = 8'd0;
          data_shift_nxt = 32'd0;
          elapsed_nxt    = 16'd0;
          push           = 1'b1;
          job.is_status  = 1'b0;
          job.cmd        = rt;
          job.addr       = reg_addr;
          job.cnt        = cnt_clamped;
          job.id         = servo_id;
          job.data       = write_word;
        end
        spm_pkg::REQ_RX: begin
          if (awaiting_r) begin
            if (byte_pos_r <= 4'd1) begin
              if (rx_byte != spm_pkg::HDR_BYTE) failed_nxt = 1'b1;
            end else if (byte_pos_r == 4'd2) begin
              if (rx_byte != servo_id) failed_nxt = 1'b1;
              run_sum_nxt = sum_add;
            end else if (byte_pos_r == 4'd3) begin
              if (rx_byte != ({5'd0, expect_len_r} + 8'd2)) failed_nxt = 1'b1;
              run_sum_nxt = sum_add;
            end else if (byte_pos_r == 4'd4) begin
              if (!failed_r) last_error_nxt = rx_byte;
              run_sum_nxt = sum_add;
            end else if (byte_pos_r < (4'd5 + {1'b0, expect_len_r})) begin
              data_shift_nxt = data_shift_r | ({24'd0, rx_byte} << {di[1:0], 3'b000});
              run_sum_nxt    = sum_add;
            end else begin
              if (rx_byte != ~run_sum_r) failed_nxt = 1'b1;
            end
            byte_pos_nxt = byte_pos_r + 4'd1;
            if (({1'b0, byte_pos_r} + 5'd1) >= ({2'b00, expect_len_r} + 5'd6)) begin
              awaiting_nxt  = 1'b0;
              push          = 1'b1;
              job.is_status = 1'b1;
              job.ok        = !failed_nxt;
              job.err       = last_error_nxt;
              job.data      = failed_nxt ? 32'd0 : data_shift_nxt;
            end
          end
        end
        spm_pkg::REQ_TICK: begin
          if (awaiting_r) begin
            if (elapsed_r != 16'hFFFF) elapsed_nxt = elapsed_r + 16'd1;
            if (elapsed_nxt >= timeout_us) begin
              awaiting_nxt  = 1'b0;
              push          = 1'b1;
              job.is_status = 1'b1;
              job.ok        = 1'b0;
              job.err       = last_error_r;
              job.data      = 32'd0;
            end
          end
        end
        default: begin
          // drop unknown request codes
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaiting_r   <= 1'b0;
      failed_r     <= 1'b0;
      expect_len_r <= 3'd0;
      byte_pos_r   <= 4'd0;
      run_sum_r    <= 8'd0;
      last_error_r <= 8'd0;
      data_shift_r <= 32'd0;
      elapsed_r    <= 16'd0;
    end else begin
      awaiting_r   <= awaiting_nxt;
      failed_r     <= failed_nxt;
      expect_len_r <= expect_len_nxt;
      byte_pos_r   <= byte_pos_nxt;
      run_sum_r    <= run_sum_nxt;
      last_error_r <= last_error_nxt;
      data_shift_r <= data_shift_nxt;
      elapsed_r    <= elapsed_nxt;
    end
  end

endmodule
`default_nettype wire

>>> src/spm_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module spm_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire spm_pkg::job_t push_job,
  input  wire logic          pop,
  output logic               full,
  output logic               nonempty,
  output spm_pkg::job_t      head
);

  localparam logic [spm_pkg::QPTR_W:0] DEPTH_CNT = (spm_pkg::QPTR_W + 1)'(spm_pkg::QDEPTH);

  spm_pkg::job_t                entries_r [spm_pkg::QDEPTH];
  logic [spm_pkg::QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [spm_pkg::QPTR_W:0]     count_r;
  logic                         do_push, do_pop;

  assign full     = (count_r == DEPTH_CNT);
  assign nonempty = (count_r != '0);
  assign head     = entries_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;

  always_ff @(posedge clk) begin
    if (do_push) entries_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

endmodule
`default_nettype wire

>>> src/spm_back.sv
`timescale 1ns / 1ps
`default_nettype none
module spm_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_nonempty,
  input  wire spm_pkg::job_t q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic               out_kind,
  output logic [7:0]         out_tx_byte,
  output logic               out_last,
  output logic               out_reply_ok,
  output logic [7:0]         out_servo_error,
  output logic [31:0]        out_read_word
);

  logic          busy_r;
  spm_pkg::job_t job_r;
  logic [3:0]    idx_r;
  logic [7:0]    sum_r, sum_nxt;

  logic          valid_r;
  logic          kind_r, last_r, ok_r;
  logic [7:0]    tx_r, err_r;
  logic [31:0]   word_r;

  logic [3:0]    last_idx, di;
  logic [7:0]    cur_byte, len_byte, instr_byte, data_byte;
  logic          advance, done;

  always_comb begin
    case (job_r.cmd)
      spm_pkg::REQ_PING: begin
        last_idx   = 4'd5;
        len_byte   = 8'd2;
        instr_byte = spm_pkg::INSTR_PING;
      end
      spm_pkg::REQ_READ: begin
        last_idx   = 4'd7;
        len_byte   = 8'd4;
        instr_byte = spm_pkg::INSTR_READ;
      end
      default: begin
        last_idx   = 4'd6 + {1'b0, job_r.cnt};
        len_byte   = {5'd0, job_r.cnt} + 8'd3;
        instr_byte = spm_pkg::INSTR_WRITE;
      end
    endcase
    if (job_r.is_status) last_idx = 4'd0;
  end

  assign di        = idx_r - 4'd6;
  assign data_byte = job_r.data[{di[1:0], 3'b000} +: 8];

  always_comb begin
    if (idx_r == last_idx) begin
      cur_byte = ~sum_r;
    end else begin
      case (idx_r)
        4'd0, 4'd1: cur_byte = spm_pkg::HDR_BYTE;
        4'd2:       cur_byte = job_r.id;
        4'd3:       cur_byte = len_byte;
        4'd4:       cur_byte = instr_byte;
        4'd5:       cur_byte = job_r.addr;
        4'd6:       cur_byte = (job_r.cmd == spm_pkg::REQ_READ) ? {5'd0, job_r.cnt} : data_byte;
        default:    cur_byte = data_byte;
      endcase
    end
  end

  assign sum_nxt = (idx_r >= 4'd2) ? sum_r + cur_byte : sum_r;
  assign advance = busy_r && (!valid_r || out_ready);
  assign done    = advance && (idx_r == last_idx);
  assign q_pop   = q_nonempty && (!busy_r || done);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 4'd0;
      sum_r  <= 8'd0;
    end else if (q_pop) begin
      busy_r <= 1'b1;
      idx_r  <= 4'd0;
      sum_r  <= 8'd0;
    end else if (done) begin
      busy_r <= 1'b0;
    end else if (advance) begin
      idx_r <= idx_r + 4'd1;
      sum_r <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) job_r <= q_head;
  end

  // output register: load when the slot is free, hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (job_r.is_status) begin
        kind_r <= spm_pkg::KIND_STATUS;
        tx_r   <= 8'd0;
        last_r <= 1'b0;
        ok_r   <= job_r.ok;
        err_r  <= job_r.err;
        word_r <= job_r.data;
      end else begin
        kind_r <= spm_pkg::KIND_TX;
        tx_r   <= cur_byte;
        last_r <= (idx_r == last_idx);
        ok_r   <= 1'b0;
        err_r  <= 8'd0;
        word_r <= 32'd0;
      end
    end
  end

  assign out_valid       = valid_r;
  assign out_kind        = kind_r;
  assign out_tx_byte     = tx_r;
  assign out_last        = last_r;
  assign out_reply_ok    = ok_r;
  assign out_servo_error = err_r;
  assign out_read_word   = word_r;

endmodule
`default_nettype wire

>>> src/servo_packet_master.sv
// Servo packet master: master side of a half-duplex servo bus.
// Input channel (in_valid/in_ready) carries one request per transaction:
// ping, read or write commands, bytes received from the line, and one-
// microsecond ticks. The output channel (out_valid/out_ready) returns frame
// bytes to transmit (out_kind 0, out_last on the checksum byte) and, per
// command answered or timed out, one status (out_kind 1) with reply_ok, the
// servo error byte and read data. cfg_we/cfg_index/cfg_data write servo_id
// (0) and timeout_us (1). Received bytes and ticks are checked in the cycle
// they are accepted; a command's frame passes through the job queue, the job
// register and the output register, and its bytes follow one per cycle while
// out_ready holds; a frame is 6 to 11 bytes. A status takes that path from the
// byte or tick that completes the command, after any frame bytes still queued.
// A 4-entry job queue sits between the request checker and the byte sender;
// input is accepted every cycle while that queue has room, so requests keep
// flowing while the output is stalled until the queue fills.
// Reset (rst_n low, synchronous) empties the queue, drops any pending reply
// and restores servo_id 1 and timeout_us 3000.
`timescale 1ns / 1ps
`default_nettype none
`include "servo_packet_master_macros.svh"
module servo_packet_master (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_req_type,
  input  wire logic [7:0]  in_reg_addr,
  input  wire logic [2:0]  in_byte_count,
  input  wire logic [31:0] in_write_word,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_kind,
  output logic [7:0]       out_tx_byte,
  output logic             out_last,
  output logic             out_reply_ok,
  output logic [7:0]       out_servo_error,
  output logic [31:0]      out_read_word,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic [7:0]    servo_id_r;
  logic [15:0]   timeout_r;
  logic          accept, push, q_full, q_nonempty, q_pop, awaiting;
  spm_pkg::job_t push_job, q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      servo_id_r <= spm_pkg::ID_RESET;
      timeout_r  <= spm_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        spm_pkg::CFG_SERVO_ID: servo_id_r <= cfg_data[7:0];
        spm_pkg::CFG_TIMEOUT:  timeout_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  spm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .req_type   (in_req_type),
    .reg_addr   (in_reg_addr),
    .byte_count (in_byte_count),
    .write_word (in_write_word),
    .rx_byte    (in_rx_byte),
    .servo_id   (servo_id_r),
    .timeout_us (timeout_r),
    .push       (push),
    .job        (push_job),
    .awaiting   (awaiting)
  );

  spm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (q_pop),
    .full     (q_full),
    .nonempty (q_nonempty),
    .head     (q_head)
  );

  spm_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_nonempty      (q_nonempty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_tx_byte     (out_tx_byte),
    .out_last        (out_last),
    .out_reply_ok    (out_reply_ok),
    .out_servo_error (out_servo_error),
    .out_read_word   (out_read_word)
  );

  `SPM_ASSERT_NEXT(a_cmd_awaits, accept && (in_req_type <= spm_pkg::REQ_WRITE), awaiting)
  `SPM_ASSERT_SAME(a_push_has_room, push, !q_full)
  `SPM_ASSERT_SAME(a_status_clean, out_valid && out_kind, !out_last && (out_tx_byte == 8'd0))
  `SPM_ASSERT_SAME(a_tx_clean, out_valid && !out_kind, !out_reply_ok && (out_read_word == 32'd0))

endmodule
`default_nettype wire
